[sv/lzwd_pkg.sv]
package lzwd_pkg;

  localparam int unsigned WindowSize = 8192;
  localparam int unsigned WinAddrW   = $clog2(WindowSize);
  localparam int unsigned LenBias    = 3;
  localparam int unsigned LenCntW    = 4;

  typedef logic [WinAddrW-1:0] win_addr_t;
  typedef logic [LenCntW-1:0]  len_cnt_t;

  localparam win_addr_t WinLast  = win_addr_t'(WindowSize - 1);
  // longest copy minus one: three length bits plus the bias
  localparam len_cnt_t  MaxLenM1 = len_cnt_t'(7 + LenBias - 1);
  localparam logic [7:0] FlagFill = 8'hff;

  // one write port and one registered read port on the history window
  typedef struct packed {
    logic      we;
    win_addr_t waddr;
    logic [7:0] wdata;
    win_addr_t raddr;
  } win_req_t;

endpackage

[sv/lzwd_window.sv]
module lzwd_window
  import lzwd_pkg::*;
(
  input  logic       clk_i,
  input  win_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [WindowSize];
  logic [7:0] rdata_q;

  // read-before-write: a read at the written address returns the old byte
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/lzss_window_decompressor_unit.sv]
// LZSS decompressor with an 8 KB history window. Each input transfer carries one
// compressed byte; a flag byte provides eight flags (low bit first), a set flag
// means a literal byte and a clear flag means a two-byte little-endian command
// whose low 13 bits are an absolute window position and whose top 3 bits plus 3
// give a copy length of 3 to 10. After reset the block sweeps the window to zero
// and is not ready during that time. A flag byte, a literal or a low command
// byte is taken in ST_IDLE. A high command byte starts a copy that alternates
// ST_READ and ST_EMIT for each copied byte: the single read port of the
// window is read, and the byte is emitted and written back before the next read,
// so overlapping copies see their own output. The block accepts no new byte
// while a copy runs; downstream stalls hold it in ST_EMIT.
module lzss_window_decompressor_unit
  import lzwd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // last_of_run
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LIT,
    PH_HIGH
  } phase_e;

  state_e     state_q;
  phase_e     phase_q;
  win_addr_t  wr_idx_q;
  win_addr_t  rd_pos_q;
  len_cnt_t   remain_q;
  logic [15:0] flag_shift_q;
  logic [7:0] held_low_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic       out_free;
  logic       in_fire;
  logic       lit_fire;
  logic       emit_fire;
  logic [15:0] flag_next;
  phase_e     phase_next;
  win_addr_t  wr_idx_inc;
  win_req_t   win_req;
  logic [7:0] rd_data;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign lit_fire        = in_fire && (phase_q == PH_LIT) && flag_shift_q[0];
  assign emit_fire       = (state_q == ST_EMIT) && out_free;

  // consume one flag; bit 8 clears once all eight are used
  assign flag_next  = {1'b0, flag_shift_q[15:1]};
  assign phase_next = flag_next[8] ? PH_LIT : PH_FLAG;
  assign wr_idx_inc = wr_idx_q + win_addr_t'(1);

  always_comb begin
    win_req.we    = (state_q == ST_CLEAR) || lit_fire || emit_fire;
    win_req.waddr = wr_idx_q;
    win_req.raddr = rd_pos_q;
    if (state_q == ST_CLEAR) begin
      win_req.wdata = 8'h00;
    end else if (lit_fire) begin
      win_req.wdata = s_axis_tdata_i;
    end else begin
      win_req.wdata = rd_data;
    end
  end

  lzwd_window u_window (
    .clk_i   (clk_i),
    .req_i   (win_req),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      phase_q      <= PH_FLAG;
      wr_idx_q     <= '0;
      rd_pos_q     <= '0;
      remain_q     <= '0;
      flag_shift_q <= '0;
      held_low_q   <= '0;
      out_valid_q  <= 1'b0;
      out_byte_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      // drop valid after a transfer unless a new byte takes its place
      if (out_valid_q && m_axis_tready_i && !lit_fire && !emit_fire) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          wr_idx_q <= wr_idx_inc;
          if (wr_idx_q == WinLast) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            case (phase_q)
              PH_LIT: begin
                if (flag_shift_q[0]) begin
                  out_valid_q  <= 1'b1;
                  out_byte_q   <= s_axis_tdata_i;
                  out_last_q   <= 1'b1;
                  wr_idx_q     <= wr_idx_inc;
                  flag_shift_q <= flag_next;
                  phase_q      <= phase_next;
                end else begin
                  held_low_q <= s_axis_tdata_i;
                  phase_q    <= PH_HIGH;
                end
              end
              PH_HIGH: begin
                rd_pos_q <= {s_axis_tdata_i[4:0], held_low_q};
                remain_q <= len_cnt_t'(s_axis_tdata_i[7:5]) + len_cnt_t'(LenBias - 1);
                state_q  <= ST_READ;
              end
              default: begin
                flag_shift_q <= {FlagFill, s_axis_tdata_i};
                phase_q      <= PH_LIT;
              end
            endcase
          end
        end
        ST_READ: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_byte_q  <= rd_data;
            out_last_q  <= (remain_q == '0);
            wr_idx_q    <= wr_idx_inc;
            rd_pos_q    <= rd_pos_q + win_addr_t'(1);
            if (remain_q == '0) begin
              flag_shift_q <= flag_next;
              phase_q      <= phase_next;
              state_q      <= ST_IDLE;
            end else begin
              remain_q <= remain_q - len_cnt_t'(1);
              state_q  <= ST_READ;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  // when output valid rises, its byte was written into the window in the previous cycle
  a_out_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(win_req.we))
    else $error("output byte not written back to window");

  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (remain_q <= MaxLenM1))
    else $error("copy count out of range");

  a_copy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && (remain_q == '0)) |=> (state_q == ST_IDLE) && m_axis_tlast_o)
    else $error("copy did not end with last byte");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!m_axis_tvalid_o && !s_axis_tready_o))
    else $error("traffic during window clear");

endmodule
